FILE: sv/wfsu_pkg.sv
// Shared types, constants and the cosine table for the wall follow steering block.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none
package wfsu_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIST_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEER_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_SPEED   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STARTUP_MS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE_MS    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PIVOT_ANGLE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_MS  = 3'd7;

    localparam logic signed [17:0] WALL_TARGET_MM = 18'sd400;
    localparam logic [14:0]        DIST_SAT       = 15'd32767;
    localparam logic [7:0]         SPEED_MARGIN   = 8'd10;
    localparam logic [3:0]         LOST_SAT       = 4'd15;
    localparam logic [3:0]         DIV_STEPS      = 4'd15;

    // Q14 quarter-wave cosine, step pi/64
    localparam logic [14:0] COS_TAB [0:32] = '{
        15'd16384, 15'd16364, 15'd16305, 15'd16207, 15'd16069, 15'd15893, 15'd15679,
        15'd15426, 15'd15137, 15'd14811, 15'd14449, 15'd14053, 15'd13623, 15'd13160,
        15'd12665, 15'd12140, 15'd11585, 15'd11003, 15'd10394, 15'd9760,  15'd9102,
        15'd8423,  15'd7723,  15'd7005,  15'd6270,  15'd5520,  15'd4756,  15'd3981,
        15'd3196,  15'd2404,  15'd1606,  15'd804,   15'd0
    };

    typedef enum logic [3:0] {
        OP_NONE, OP_CAP, OP_DIV_INIT, OP_DIV_STEP, OP_DIV_SAVE, OP_SEL,
        OP_MUL1, OP_MUL2, OP_MUL3, OP_ADD, OP_OUT, OP_SET_PHASE, OP_SET_YAW
    } t_dp_op;

    typedef enum logic [1:0] {
        K_FOLLOW, K_PIVOT, K_REVERSE
    } t_out_kind;

    typedef struct packed {
        t_dp_op    op;
        logic      line;
        t_out_kind kind;
    } t_dp_cmd;

    typedef struct packed {
        logic       early;
        logic       pause_done;
        logic       rev_done;
        logic       yaw_done;
        logic       div_done;
        logic [1:0] wall;
    } t_dp_stat;

    // interpolated cosine magnitude, q is the folded angle in 1/32768 of pi/2 ... pi
    function automatic logic [14:0] cos_mag(input logic [15:0] q);
        logic [5:0]  idx;
        logic [9:0]  frac;
        logic [9:0]  dlt;
        logic [19:0] pr;
        begin
            idx  = q[15:10];
            frac = q[9:0];
            if (idx >= 6'd32) begin
                return 15'd0;
            end
            dlt = 10'(COS_TAB[idx] - COS_TAB[6'(idx + 6'd1)]);
            pr  = 20'(dlt) * 20'(frac);
            return COS_TAB[idx] - 15'(pr >> 10);
        end
    endfunction

endpackage
`default_nettype wire

FILE: sv/wfsu_in_if.sv
// Input channel: one sensor tick beat with valid/ready handshake.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface wfsu_in_if;
    logic               valid;
    logic               ready;
    logic [31:0]        now_ms;
    logic [1:0]         wall_seen;
    logic signed [14:0] first_rho;
    logic [11:0]        first_angle;
    logic signed [14:0] second_rho;
    logic [11:0]        second_angle;
    logic signed [15:0] yaw_now;

    modport source (output valid, now_ms, wall_seen, first_rho, first_angle,
                    second_rho, second_angle, yaw_now, input ready);
    modport sink   (input valid, now_ms, wall_seen, first_rho, first_angle,
                    second_rho, second_angle, yaw_now, output ready);
endinterface
`default_nettype wire

FILE: sv/wfsu_out_if.sv
// Output channel: one wheel command beat with valid/ready handshake.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface wfsu_out_if;
    logic              valid;
    logic              ready;
    logic signed [8:0] left_speed;
    logic signed [8:0] right_speed;
    logic              turning;

    modport source (output valid, left_speed, right_speed, turning, input ready);
    modport sink   (input valid, left_speed, right_speed, turning, output ready);
endinterface
`default_nettype wire

FILE: sv/wfsu_dpath.sv
// Datapath: config registers, input capture, cosine, radix-2 divider, steering math.
// Depends on wfsu_pkg; driven by commands from wfsu_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module wfsu_dpath #(
    parameter int ANGLE_BITS = 12
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire  [wfsu_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [wfsu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire  [31:0]                     i_now_ms,
    input  wire  [1:0]                      i_wall_seen,
    input  wire  signed [14:0]              i_first_rho,
    input  wire  [11:0]                     i_first_angle,
    input  wire  signed [14:0]              i_second_rho,
    input  wire  [11:0]                     i_second_angle,
    input  wire  signed [15:0]              i_yaw_now,
    input  wfsu_pkg::t_dp_cmd               i_cmd,
    output wfsu_pkg::t_dp_stat              o_stat,
    output logic signed [8:0]               o_left_speed,
    output logic signed [8:0]               o_right_speed,
    output logic                            o_turning
);
    import wfsu_pkg::*;

    localparam int TW = ANGLE_BITS + 2;
    localparam logic [ANGLE_BITS:0] HALF_TURN = (ANGLE_BITS + 1)'(1) << (ANGLE_BITS - 1);
    localparam logic signed [TW-1:0] FULL_TURN = TW'(1) << ANGLE_BITS;

    // config
    logic [15:0] r_dist_gain, r_steer_gain, r_startup_ms, r_pause_ms, r_reverse_ms;
    logic [7:0]  r_top_speed;
    logic [10:0] r_wall_offset;
    logic [14:0] r_pivot_angle;

    // captured tick
    logic [31:0]               r_now;
    logic [1:0]                r_wall;
    logic signed [14:0]        r_rho0, r_rho1;
    logic [ANGLE_BITS-1:0]     r_a0, r_a1;
    logic [15:0]               r_yaw;

    // u-turn data
    logic [31:0] r_phase_ms;
    logic [15:0] r_pivot_yaw;

    // divider
    logic [14:0] r_den, r_rem, r_num, r_quo;
    logic [3:0]  r_dcnt;
    logic        r_sat, r_zero, r_rho_neg, r_rho_zero, r_cos_neg;
    logic signed [15:0] r_d0, r_d1;

    // steering
    logic signed [17:0]   r_err;
    logic signed [TW-1:0] r_theta;
    logic [35:0]          r_dabs;
    logic                 r_dneg;
    logic [33:0]          r_plo, r_phi;
    logic [51:0]          r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_gain   <= 16'd256;
            r_steer_gain  <= 16'd4096;
            r_top_speed   <= 8'd100;
            r_wall_offset <= 11'd0;
            r_startup_ms  <= 16'd2000;
            r_pause_ms    <= 16'd500;
            r_pivot_angle <= 15'd8192;
            r_reverse_ms  <= 16'd1000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DIST_GAIN:   r_dist_gain   <= i_cfg_data;
                REG_STEER_GAIN:  r_steer_gain  <= i_cfg_data;
                REG_TOP_SPEED:   r_top_speed   <= i_cfg_data[7:0];
                REG_WALL_OFFSET: r_wall_offset <= i_cfg_data[10:0];
                REG_STARTUP_MS:  r_startup_ms  <= i_cfg_data;
                REG_PAUSE_MS:    r_pause_ms    <= i_cfg_data;
                REG_PIVOT_ANGLE: r_pivot_angle <= i_cfg_data[14:0];
                REG_REVERSE_MS:  r_reverse_ms  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // line select for the divider
    logic signed [14:0]    w_rho;
    logic [ANGLE_BITS-1:0] w_ang;
    logic [16:0]           w_p;
    logic                  w_cneg;
    logic [15:0]           w_q;
    logic [14:0]           w_cmag;
    logic [14:0]           w_rabs;
    logic [15:0]           w_t;
    logic [15:0]           w_tsub;

    always_comb begin
        w_rho  = i_cmd.line ? r_rho1 : r_rho0;
        w_ang  = i_cmd.line ? r_a1 : r_a0;
        w_p    = 17'(w_ang) << (16 - ANGLE_BITS);
        w_cneg = w_p > 17'd32768;
        w_q    = w_cneg ? 16'(17'd65536 - w_p) : w_p[15:0];
        w_cmag = cos_mag(w_q);
        w_rabs = w_rho[14] ? 15'(-w_rho) : 15'(w_rho);
        w_t    = {r_rem, r_num[14]};
        w_tsub = w_t - {1'b0, r_den};
    end

    // heading folds and error select
    logic signed [TW-1:0] w_f0, w_f1;
    logic signed [17:0]   w_e0, w_e1, w_ae0, w_ae1, w_off;

    always_comb begin
        w_f0  = ({1'b0, r_a0} > HALF_TURN) ? TW'($signed({2'b0, r_a0})) - FULL_TURN
                                           : TW'($signed({2'b0, r_a0}));
        w_f1  = ({1'b0, r_a1} > HALF_TURN) ? TW'($signed({2'b0, r_a1})) - FULL_TURN
                                           : TW'($signed({2'b0, r_a1}));
        w_e0  = 18'(r_d0) - WALL_TARGET_MM;
        w_e1  = 18'(r_d1) - WALL_TARGET_MM;
        w_ae0 = w_e0[17] ? -w_e0 : w_e0;
        w_ae1 = w_e1[17] ? -w_e1 : w_e1;
        w_off = $signed({7'b0, r_wall_offset});
    end

    logic signed [35:0] w_dth;
    logic [14:0]        w_dmag;
    logic               w_dsgn;

    always_comb begin
        w_dth  = 36'(r_err * $signed({2'b0, r_dist_gain})) - (36'(r_theta) <<< 8);
        w_dmag = r_zero ? (r_rho_zero ? 15'd0 : DIST_SAT) : (r_sat ? DIST_SAT : r_quo);
        w_dsgn = r_zero ? r_rho_neg : (r_rho_neg ^ r_cos_neg);
    end

    // output forming
    logic [7:0]        w_lim, w_magc;
    logic [31:0]       w_mag;
    logic signed [8:0] w_sv;

    always_comb begin
        w_lim  = (r_top_speed > SPEED_MARGIN) ? r_top_speed - SPEED_MARGIN : 8'd0;
        w_mag  = r_sum[51:20];
        w_magc = (w_mag > 32'(w_lim)) ? w_lim : w_mag[7:0];
        w_sv   = $signed({1'b0, r_top_speed});
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAP: begin
                r_now  <= i_now_ms;
                r_wall <= i_wall_seen;
                r_rho0 <= i_first_rho;
                r_rho1 <= i_second_rho;
                r_a0   <= ANGLE_BITS'(16'(i_first_angle));
                r_a1   <= ANGLE_BITS'(16'(i_second_angle));
                r_yaw  <= i_yaw_now;
            end
            OP_DIV_INIT: begin
                r_den      <= w_cmag;
                r_cos_neg  <= w_cneg;
                r_rho_neg  <= w_rho[14];
                r_rho_zero <= (w_rho == 15'sd0);
                r_zero     <= (w_cmag == 15'd0);
                r_sat      <= {1'b0, w_rabs} >= {w_cmag, 1'b0};
                r_rem      <= {1'b0, w_rabs[14:1]};
                r_num      <= {w_rabs[0], 14'b0};
                r_quo      <= 15'd0;
                r_dcnt     <= DIV_STEPS;
            end
            OP_DIV_STEP: begin
                if (w_t >= {1'b0, r_den}) begin
                    r_rem <= w_tsub[14:0];
                    r_quo <= {r_quo[13:0], 1'b1};
                end else begin
                    r_rem <= w_t[14:0];
                    r_quo <= {r_quo[13:0], 1'b0};
                end
                r_num  <= {r_num[13:0], 1'b0};
                r_dcnt <= r_dcnt - 4'd1;
            end
            OP_DIV_SAVE: begin
                if (i_cmd.line) begin
                    r_d1 <= w_dsgn ? -$signed({1'b0, w_dmag}) : $signed({1'b0, w_dmag});
                end else begin
                    r_d0 <= w_dsgn ? -$signed({1'b0, w_dmag}) : $signed({1'b0, w_dmag});
                end
            end
            OP_SEL: begin
                case (r_wall)
                    2'd1: begin
                        r_err   <= w_e0 - w_off;
                        r_theta <= w_f0;
                    end
                    2'd2: begin
                        r_err   <= w_e0 + w_off;
                        r_theta <= -w_f0;
                    end
                    2'd3: begin
                        if (w_ae0 < w_ae1) begin
                            r_err   <= w_e0 + w_off;
                            r_theta <= -w_f0;
                        end else begin
                            r_err   <= w_e1 - w_off;
                            r_theta <= w_f1;
                        end
                    end
                    default: begin
                        r_err   <= 18'sd0;
                        r_theta <= '0;
                    end
                endcase
            end
            OP_MUL1: begin
                r_dabs <= w_dth[35] ? 36'(-w_dth) : 36'(w_dth);
                r_dneg <= w_dth[35];
            end
            OP_MUL2: r_plo <= r_dabs[17:0] * r_steer_gain;
            OP_MUL3: r_phi <= r_dabs[35:18] * r_steer_gain;
            OP_ADD:  r_sum <= 52'(r_plo) + (52'(r_phi) << 18);
            OP_OUT: begin
                case (i_cmd.kind)
                    K_PIVOT: begin
                        o_left_speed  <= $signed({3'b0, r_top_speed[7:2]});
                        o_right_speed <= w_sv;
                        o_turning     <= 1'b1;
                    end
                    K_REVERSE: begin
                        o_left_speed  <= -w_sv;
                        o_right_speed <= -w_sv;
                        o_turning     <= 1'b1;
                    end
                    default: begin
                        if (r_dneg || w_magc == 8'd0) begin
                            o_left_speed  <= w_sv - $signed({1'b0, w_magc});
                            o_right_speed <= w_sv;
                        end else begin
                            o_left_speed  <= w_sv;
                            o_right_speed <= w_sv - $signed({1'b0, w_magc});
                        end
                        o_turning <= 1'b0;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // u-turn reference points, state that reset clears
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ms  <= 32'd0;
            r_pivot_yaw <= 16'd0;
        end else if (i_cmd.op == OP_SET_PHASE) begin
            r_phase_ms <= r_now;
        end else if (i_cmd.op == OP_SET_YAW) begin
            r_pivot_yaw <= r_yaw;
        end
    end

    logic [31:0] w_elapsed;
    logic [15:0] w_dyaw;

    always_comb begin
        w_elapsed         = r_now - r_phase_ms;
        w_dyaw            = r_yaw - r_pivot_yaw;
        o_stat.early      = r_now < 32'(r_startup_ms);
        o_stat.pause_done = w_elapsed > 32'(r_pause_ms);
        o_stat.rev_done   = w_elapsed > 32'(r_reverse_ms);
        o_stat.yaw_done   = $signed(w_dyaw) > $signed({1'b0, r_pivot_angle});
        o_stat.div_done   = (r_dcnt == 4'd0);
        o_stat.wall       = r_wall;
    end

endmodule
`default_nettype wire

FILE: sv/wfsu_ctrl.sv
// Controller: sequences one tick through follow steering or a U-turn step.
// Depends on wfsu_pkg; commands wfsu_dpath and owns the channel handshakes.
`timescale 1ns / 1ps
`default_nettype none
module wfsu_ctrl #(
    parameter int LOST_LIMIT = 10
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    input  wfsu_pkg::t_dp_stat  i_stat,
    output wfsu_pkg::t_dp_cmd   o_cmd
);
    import wfsu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_DINIT, S_DRUN, S_SEL, S_MUL1, S_MUL2, S_MUL3, S_ADD, S_EMIT
    } t_state;

    t_state    r_state;
    logic      r_active;
    logic [1:0] r_step;
    logic [3:0] r_lost;
    logic      r_line;
    t_out_kind r_kind;

    logic [3:0] w_lost_inc;
    logic       w_emit;

    always_comb begin
        w_lost_inc = (r_lost < LOST_SAT) ? r_lost + 4'd1 : r_lost;
        w_emit     = (r_state == S_EMIT) && (!o_out_valid || i_out_ready);
        o_in_ready = (r_state == S_IDLE);
        o_cmd.op   = OP_NONE;
        o_cmd.line = r_line;
        o_cmd.kind = r_kind;
        case (r_state)
            S_IDLE:   if (i_in_valid) o_cmd.op = OP_CAP;
            S_DECIDE: begin
                if (r_active) begin
                    case (r_step)
                        2'd0: if (i_stat.pause_done) o_cmd.op = OP_SET_YAW;
                        2'd2: if (i_stat.rev_done) o_cmd.op = OP_SET_YAW;
                        default: if (i_stat.yaw_done) o_cmd.op = OP_SET_PHASE;
                    endcase
                end else if (!i_stat.early && i_stat.wall == 2'd0 &&
                             w_lost_inc > 4'(LOST_LIMIT)) begin
                    o_cmd.op = OP_SET_PHASE;
                end
            end
            S_DINIT: o_cmd.op = OP_DIV_INIT;
            S_DRUN:  o_cmd.op = i_stat.div_done ? OP_DIV_SAVE : OP_DIV_STEP;
            S_SEL:   o_cmd.op = OP_SEL;
            S_MUL1:  o_cmd.op = OP_MUL1;
            S_MUL2:  o_cmd.op = OP_MUL2;
            S_MUL3:  o_cmd.op = OP_MUL3;
            S_ADD:   o_cmd.op = OP_ADD;
            S_EMIT:  if (w_emit) o_cmd.op = OP_OUT;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= 1'b0;
            r_step      <= 2'd0;
            r_lost      <= 4'd0;
            r_line      <= 1'b0;
            r_kind      <= K_FOLLOW;
            o_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: if (i_in_valid) r_state <= S_DECIDE;
                S_DECIDE: begin
                    if (r_active) begin
                        case (r_step)
                            2'd0: begin
                                if (i_stat.pause_done) r_step <= 2'd1;
                                r_state <= S_IDLE;
                            end
                            2'd1: begin
                                if (i_stat.yaw_done) r_step <= 2'd2;
                                r_kind  <= K_PIVOT;
                                r_state <= S_EMIT;
                            end
                            2'd2: begin
                                if (i_stat.rev_done) r_step <= 2'd3;
                                r_kind  <= K_REVERSE;
                                r_state <= S_EMIT;
                            end
                            default: begin
                                if (i_stat.yaw_done) r_active <= 1'b0;
                                r_kind  <= K_PIVOT;
                                r_state <= S_EMIT;
                            end
                        endcase
                    end else if (i_stat.early) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_kind <= K_FOLLOW;
                        r_line <= 1'b0;
                        if (i_stat.wall == 2'd0) begin
                            r_lost <= w_lost_inc;
                            if (w_lost_inc > 4'(LOST_LIMIT)) begin
                                r_active <= 1'b1;
                                r_step   <= 2'd0;
                            end
                            r_state <= S_SEL;
                        end else begin
                            r_lost  <= 4'd0;
                            r_state <= S_DINIT;
                        end
                    end
                end
                S_DINIT: r_state <= S_DRUN;
                S_DRUN: begin
                    if (i_stat.div_done) begin
                        if (!r_line && i_stat.wall == 2'd3) begin
                            r_line  <= 1'b1;
                            r_state <= S_DINIT;
                        end else begin
                            r_state <= S_SEL;
                        end
                    end
                end
                S_SEL:  r_state <= S_MUL1;
                S_MUL1: r_state <= S_MUL2;
                S_MUL2: r_state <= S_MUL3;
                S_MUL3: r_state <= S_ADD;
                S_ADD:  r_state <= S_EMIT;
                S_EMIT: if (w_emit) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: sv/wall_follow_steering_with_uturn.sv
// Top level of the wall follow steering block with U-turn sequencer.
// Depends on wfsu_pkg, wfsu_in_if, wfsu_out_if, wfsu_ctrl and wfsu_dpath.
//
//  Channel   Dir  Handshake          Beat
//  i_in      in   valid/ready        one sensor tick (time, walls, two lines, yaw)
//  o_out     out  valid/ready        wheel speeds and turning flag
//  i_cfg_*   in   write enable only  one register write, index + data
//
// One tick at a time. A follow tick runs one rho/cos quotient per wall seen
// through the radix-2 divider, then select, the distance gain product, two
// multiply stages split in halves, an add and the output load. A follow tick
// with no wall skips the divider. Pivot and reverse ticks go straight to the
// output load; pause and startup ticks give no beat. Reset (synchronous, low)
// restores register defaults and clears the U-turn state. A result waits in
// the output register; the next tick is taken then, but stalls in the emit
// step if the previous beat has still not been taken.
`timescale 1ns / 1ps
`default_nettype none
module wall_follow_steering_with_uturn #(
    parameter int ANGLE_BITS = 12,
    parameter int LOST_LIMIT = 10
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    wfsu_in_if.sink                         i_in,
    wfsu_out_if.source                      o_out,
    input  wire                             i_cfg_we,
    input  wire  [wfsu_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [wfsu_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import wfsu_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // controller: handshakes, lost counter, U-turn step
    wfsu_ctrl #(
        .LOST_LIMIT (LOST_LIMIT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // datapath: config, divider, steering arithmetic, output payload
    wfsu_dpath #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_now_ms       (i_in.now_ms),
        .i_wall_seen    (i_in.wall_seen),
        .i_first_rho    (i_in.first_rho),
        .i_first_angle  (i_in.first_angle),
        .i_second_rho   (i_in.second_rho),
        .i_second_angle (i_in.second_angle),
        .i_yaw_now      (i_in.yaw_now),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_left_speed   (o_out.left_speed),
        .o_right_speed  (o_out.right_speed),
        .o_turning      (o_out.turning)
    );

    // one tick at a time: busy right after a beat is taken
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input ready right after a taken beat");

    // pivot or reverse never drives the left wheel faster than the right
    a_turn_speeds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.turning) |-> (o_out.left_speed <= o_out.right_speed))
        else $error("U-turn beat with left faster than right");

    // follow mode only ever slows a wheel, never reverses it
    a_follow_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.turning) |->
            (!o_out.left_speed[8] && !o_out.right_speed[8]))
        else $error("follow beat with a reversed wheel");

    // divider is never stepped past its last iteration
    a_div_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == OP_DIV_STEP) |-> !w_stat.div_done)
        else $error("divider stepped after completion");

endmodule
`default_nettype wire

FILE: tb/wall_follow_steering_with_uturn_tb.sv
// Self-checking bench for wall_follow_steering_with_uturn: directed tick table, then random phases.
// Depends on wfsu_pkg, wfsu_in_if, wfsu_out_if and the RTL of the block.
`timescale 1ns / 1ps
module wall_follow_steering_with_uturn_tb;
    import wfsu_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 100;   // covers a two-wall tick plus margin
    localparam int SETTLE_CYCLES = 60;    // a tick with no result may still be in flight
    localparam int MAX_REPORTS   = 10;
    localparam int LOST_TICKS    = 10;
    localparam int DIST_LIMIT    = 32767;
    localparam int TARGET_MM     = 400;

    localparam logic [1:0] WALL_NONE  = 2'd0;
    localparam logic [1:0] WALL_RIGHT = 2'd1;
    localparam logic [1:0] WALL_LEFT  = 2'd2;
    localparam logic [1:0] WALL_BOTH  = 2'd3;

    typedef enum int {UT_PAUSE, UT_PIVOT_OUT, UT_REVERSE, UT_PIVOT_BACK} uturn_step_t;

    typedef struct {
        logic [31:0]        now;
        logic [1:0]         wall;
        logic signed [14:0] rho0;
        logic [11:0]        ang0;
        logic signed [14:0] rho1;
        logic [11:0]        ang1;
        logic signed [15:0] yaw;
    } tick_t;

    typedef struct packed {
        logic signed [8:0] left;
        logic signed [8:0] right;
        logic              turning;
    } wheel_cmd_t;

    typedef struct {
        tick_t      t;
        bit         typed;
        wheel_cmd_t cmd;
    } tick_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = '0;
    logic [15:0] cfg_data = '0;

    wfsu_in_if  tick_ch();
    wfsu_out_if cmd_ch();

    wall_follow_steering_with_uturn dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (tick_ch),
        .o_out      (cmd_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // mirror of the block's registers and U-turn state
    int unsigned dist_gain_r, steer_gain_r, top_speed_r, wall_offset_r;
    int unsigned startup_r, pause_r, pivot_r, reverse_r;
    bit          uturn_on;
    uturn_step_t uturn_step;
    int          lost_count;
    logic [31:0] phase_start;
    logic [15:0] pivot_yaw;

    wheel_cmd_t  cmd_expected[$];
    int          mismatches;
    int          cycles;
    int          hold_left;     // receiver hold-off, counted down by the receiver
    bit          tx_no_idle;
    bit          rx_no_idle;
    int unsigned cfg_next[8];

    initial begin
        tick_ch.valid        = 1'b0;
        tick_ch.now_ms       = '0;
        tick_ch.wall_seen    = '0;
        tick_ch.first_rho    = '0;
        tick_ch.first_angle  = '0;
        tick_ch.second_rho   = '0;
        tick_ch.second_angle = '0;
        tick_ch.yaw_now      = '0;
        cmd_ch.ready         = 1'b0;
    end

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------

    // Q14 cosine, interpolated over the quarter-wave table, signed
    function automatic int cosine_q14(input logic [11:0] ang);
        int p, q, i, f, mag;
        bit neg;
        p   = int'(ang) << 4;
        neg = p > 32768;
        q   = neg ? 65536 - p : p;
        i   = q >> 10;
        f   = q & 1023;
        if (i >= 32) begin
            mag = 0;
        end else begin
            mag = int'(COS_TAB[i])
                - (((int'(COS_TAB[i]) - int'(COS_TAB[i+1])) * f) >> 10);
        end
        return neg ? -mag : mag;
    endfunction

    // rho / cos, truncated toward zero and saturated
    function automatic int wall_distance(input int rho, input logic [11:0] ang);
        int c, num, den, q;
        c = cosine_q14(ang);
        if (c == 0) begin
            return (rho == 0) ? 0 : ((rho > 0) ? DIST_LIMIT : -DIST_LIMIT);
        end
        num = (rho < 0 ? -rho : rho) << 14;
        den = c < 0 ? -c : c;
        q   = num / den;
        if (q > DIST_LIMIT) q = DIST_LIMIT;
        return ((rho < 0) != (c < 0)) ? -q : q;
    endfunction

    // heading error for a wall on the right; left wall negates it
    function automatic int heading_right(input logic [11:0] ang);
        return (ang > 12'd2048) ? int'(ang) - 4096 : int'(ang);
    endfunction

    function automatic wheel_cmd_t wheels(input int l, input int r, input bit turn);
        wheel_cmd_t c;
        c.left    = l[8:0];
        c.right   = r[8:0];
        c.turning = turn;
        return c;
    endfunction

    // One tick through the steering law; returns 1 when a command comes out.
    function automatic bit steer_predict(input tick_t t, output wheel_cmd_t c);
        int          vmax, off, err, theta, e0, e1, lim, dv;
        longint      dth, prod, mag;
        logic [31:0] elapsed;
        logic [15:0] turned;
        vmax  = int'(top_speed_r);
        off   = int'(wall_offset_r);
        err   = 0;
        theta = 0;
        c     = '0;
        if (!uturn_on) begin
            if (t.now < startup_r) return 1'b0;
            case (t.wall)
                WALL_RIGHT: begin
                    lost_count = 0;
                    theta = heading_right(t.ang0);
                    err   = wall_distance(t.rho0, t.ang0) - TARGET_MM - off;
                end
                WALL_LEFT: begin
                    lost_count = 0;
                    theta = -heading_right(t.ang0);
                    err   = wall_distance(t.rho0, t.ang0) - TARGET_MM + off;
                end
                WALL_BOTH: begin
                    lost_count = 0;
                    e0 = wall_distance(t.rho0, t.ang0) - TARGET_MM;
                    e1 = wall_distance(t.rho1, t.ang1) - TARGET_MM;
                    // nearer wall wins, a tie goes to the second line
                    if ((e0 < 0 ? -e0 : e0) < (e1 < 0 ? -e1 : e1)) begin
                        err   = e0 + off;
                        theta = -heading_right(t.ang0);
                    end else begin
                        err   = e1 - off;
                        theta = heading_right(t.ang1);
                    end
                end
                default: begin
                    if (lost_count < 15) lost_count++;
                    if (lost_count > LOST_TICKS) begin
                        uturn_on    = 1'b1;
                        uturn_step  = UT_PAUSE;
                        phase_start = t.now;
                    end
                end
            endcase
            dth  = longint'(err) * longint'(dist_gain_r) - longint'(theta) * 256;
            prod = dth * longint'(steer_gain_r);
            mag  = (prod < 0 ? -prod : prod) >>> 20;
            lim  = vmax > 10 ? vmax - 10 : 0;
            if (mag > lim) mag = lim;
            dv = prod < 0 ? -int'(mag) : int'(mag);
            c  = (dv <= 0) ? wheels(vmax + dv, vmax, 1'b0) : wheels(vmax, vmax - dv, 1'b0);
            return 1'b1;
        end
        elapsed = t.now - phase_start;
        turned  = t.yaw - pivot_yaw;
        case (uturn_step)
            UT_PAUSE: begin
                if (elapsed > pause_r) begin
                    pivot_yaw  = t.yaw;
                    uturn_step = UT_PIVOT_OUT;
                end
                return 1'b0;
            end
            UT_PIVOT_OUT: begin
                c = wheels(vmax / 4, vmax, 1'b1);
                if (int'($signed(turned)) > int'(pivot_r)) begin
                    phase_start = t.now;
                    uturn_step  = UT_REVERSE;
                end
            end
            UT_REVERSE: begin
                c = wheels(-vmax, -vmax, 1'b1);
                if (elapsed > reverse_r) begin
                    pivot_yaw  = t.yaw;
                    uturn_step = UT_PIVOT_BACK;
                end
            end
            default: begin
                c = wheels(vmax / 4, vmax, 1'b1);
                if (int'($signed(turned)) > int'(pivot_r)) begin
                    phase_start = t.now;
                    uturn_on    = 1'b0;
                end
            end
        endcase
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Drivers (entered just after a rising edge)
    // ---------------------------------------------------------------

    // back-to-back register writes from cfg_next, mirrored in the predictor
    task automatic write_regs();
        for (int i = 0; i < 8; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= 3'(i);
            cfg_data <= cfg_next[i][15:0];
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
        dist_gain_r   = cfg_next[REG_DIST_GAIN] & 32'hFFFF;
        steer_gain_r  = cfg_next[REG_STEER_GAIN] & 32'hFFFF;
        top_speed_r   = cfg_next[REG_TOP_SPEED] & 32'hFF;
        wall_offset_r = cfg_next[REG_WALL_OFFSET] & 32'h7FF;
        startup_r     = cfg_next[REG_STARTUP_MS] & 32'hFFFF;
        pause_r       = cfg_next[REG_PAUSE_MS] & 32'hFFFF;
        pivot_r       = cfg_next[REG_PIVOT_ANGLE] & 32'h7FFF;
        reverse_r     = cfg_next[REG_REVERSE_MS] & 32'hFFFF;
    endtask

    // offer one tick beat, wait for it to be taken, then predict
    task automatic send_tick(input tick_t t, input bit typed, input wheel_cmd_t typed_cmd);
        wheel_cmd_t c;
        if (!tx_no_idle && $urandom_range(0, 99) < 28) begin
            tick_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        tick_ch.valid        <= 1'b1;
        tick_ch.now_ms       <= t.now;
        tick_ch.wall_seen    <= t.wall;
        tick_ch.first_rho    <= t.rho0;
        tick_ch.first_angle  <= t.ang0;
        tick_ch.second_rho   <= t.rho1;
        tick_ch.second_angle <= t.ang1;
        tick_ch.yaw_now      <= t.yaw;
        do @(posedge i_clk); while (!tick_ch.ready);
        if (steer_predict(t, c)) cmd_expected.push_back(typed ? typed_cmd : c);
    endtask

    // phase boundary: all commands back, in-flight no-result tick settled
    task automatic quiesce();
        tick_ch.valid <= 1'b0;
        while (cmd_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Receiver: random ready, long hold-off on request
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            cmd_ch.ready <= 1'b0;
        end else begin
            cmd_ch.ready <= rx_no_idle ? 1'b1 : ($urandom_range(0, 99) >= 28);
        end
    end

    // ---------------------------------------------------------------
    // Checker: every accepted command beat against the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        wheel_cmd_t exp_cmd;
        if (i_rst_n && cmd_ch.valid && cmd_ch.ready) begin
            if (cmd_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected command: left %0d right %0d turning %0b",
                             cmd_ch.left_speed, cmd_ch.right_speed, cmd_ch.turning);
            end else begin
                exp_cmd = cmd_expected.pop_front();
                if (cmd_ch.left_speed !== exp_cmd.left || cmd_ch.right_speed !== exp_cmd.right
                        || cmd_ch.turning !== exp_cmd.turning) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("command mismatch: exp %0d/%0d/%0b got %0d/%0d/%0b",
                                 exp_cmd.left, exp_cmd.right, exp_cmd.turning,
                                 cmd_ch.left_speed, cmd_ch.right_speed, cmd_ch.turning);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Directed ticks under reset configuration (vmax 100, gains 256 / 4096,
    // startup 2000). Typed rows are the obvious ones: straight ahead, and
    // errors so large that the clamp at vmax-10 decides.
    // ---------------------------------------------------------------
    tick_row_t directed[16] = '{
        // still inside the startup window: nothing comes out
        '{'{32'd0,    WALL_RIGHT, 15'sd400,    12'd0,    15'sd0,     12'd0,    16'sd0}, 0, '0},
        '{'{32'd1999, WALL_BOTH,  15'sd400,    12'd0,    15'sd400,   12'd0,    16'sd0}, 0, '0},
        // no wall: both wheels at vmax
        '{'{32'd2000, WALL_NONE,  15'sd0,      12'd0,    15'sd0,     12'd0,    16'sd0},
          1, '{9'sd100, 9'sd100, 1'b0}},
        // exactly on target
        '{'{32'd2001, WALL_RIGHT, 15'sd400,    12'd0,    15'sd0,     12'd0,    16'sd0},
          1, '{9'sd100, 9'sd100, 1'b0}},
        // rho extremes, clamped
        '{'{32'd2002, WALL_RIGHT, 15'sd16383,  12'd0,    15'sd0,     12'd0,    16'sd0},
          1, '{9'sd100, 9'sd10, 1'b0}},
        '{'{32'd2003, WALL_RIGHT, -15'sd16384, 12'd0,    15'sd0,     12'd0,    16'sd0},
          1, '{9'sd10, 9'sd100, 1'b0}},
        // zero cosine: nonzero rho saturates, zero rho gives zero distance
        '{'{32'd2004, WALL_RIGHT, 15'sd1000,   12'd2048, 15'sd0,     12'd0,    16'sd0},
          1, '{9'sd100, 9'sd10, 1'b0}},
        '{'{32'd2005, WALL_RIGHT, 15'sd0,      12'd2048, 15'sd0,     12'd0,    16'sd0},
          1, '{9'sd10, 9'sd100, 1'b0}},
        // left wall, angles at the ends of the range
        '{'{32'd2006, WALL_LEFT,  15'sd500,    12'd4095, 15'sd0,     12'd0,    16'sd0}, 0, '0},
        '{'{32'd2007, WALL_LEFT,  -15'sd300,   12'd2049, 15'sd0,     12'd0,    16'sd0}, 0, '0},
        // both walls: tie goes to the second line, then nearer wins
        '{'{32'd2008, WALL_BOTH,  15'sd600,    12'd100,  15'sd600,   12'd100,  16'sd0}, 0, '0},
        '{'{32'd2009, WALL_BOTH,  15'sd450,    12'd10,   15'sd800,   12'd4000, 16'sd0}, 0, '0},
        '{'{32'd2010, WALL_BOTH,  -15'sd16384, 12'd4095, 15'sd16383, 12'd1,    16'sd0}, 0, '0},
        '{'{32'd2011, WALL_RIGHT, 15'sd420,    12'd1024, 15'sd0,     12'd0,    -16'sd32768}, 0, '0},
        '{'{32'd2012, WALL_LEFT,  15'sd380,    12'd3072, 15'sd0,     12'd0,    16'sd32767}, 0, '0},
        '{'{32'd2013, WALL_RIGHT, 15'sd400,    12'd2047, -15'sd1,    12'd4095, 16'sd0}, 0, '0}
    };

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        tick_t       t;
        logic [31:0] now_acc;
        logic [15:0] yaw_acc;
        int          lost_run;
        mismatches = 0;
        cycles     = 0;
        hold_left  = 0;
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;

        // reset values of the mirror
        dist_gain_r = 256;  steer_gain_r = 4096; top_speed_r = 100; wall_offset_r = 0;
        startup_r   = 2000; pause_r      = 500;  pivot_r     = 8192; reverse_r    = 1000;
        uturn_on = 1'b0; uturn_step = UT_PAUSE; lost_count = 0;
        phase_start = '0; pivot_yaw = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) send_tick(directed[i].t, directed[i].typed, directed[i].cmd);

        // eleven ticks with no wall start the U-turn
        t = directed[0].t;
        t.wall = WALL_NONE;
        for (int i = 0; i < LOST_TICKS + 1; i++) begin
            t.now = 32'd2100 + 32'(i);
            send_tick(t, 1'b0, '0);
        end

        now_acc  = 32'd3000;
        yaw_acc  = '0;
        lost_run = 0;
        for (int ph = 0; ph < 9; ph++) begin
            quiesce();
            case (ph)
                0: cfg_next = '{0, 0, 11, 0, 0, 0, 0, 0};
                1: begin
                    cfg_next = '{65535, 65535, 255, 2000, 65535, 65535, 32767, 65535};
                    now_acc  = now_acc + 32'd70000;
                end
                2: cfg_next = '{256, 4096, 5, 100, 0, 200, 3000, 200};   // slow top speed
                default: begin
                    cfg_next[0] = $urandom_range(0, 99) < 20 ? $urandom_range(0, 65535)
                                                             : $urandom_range(0, 1023);
                    cfg_next[1] = $urandom_range(0, 65535);
                    cfg_next[2] = $urandom_range(0, 99) < 10 ? $urandom_range(0, 10)
                                                             : $urandom_range(11, 255);
                    cfg_next[3] = $urandom_range(0, 2000);
                    cfg_next[4] = $urandom_range(0, 3000);
                    cfg_next[5] = $urandom_range(0, 1500);
                    cfg_next[6] = $urandom_range(0, 12000);
                    cfg_next[7] = $urandom_range(0, 1500);
                end
            endcase
            write_regs();

            // phase 3: receiver holds off while ticks keep coming
            tx_no_idle = (ph == 3 || ph == 5);
            rx_no_idle = (ph == 5);
            if (ph == 3) hold_left = 400;

            for (int k = 0; k < 58; k++) begin
                if ($urandom_range(0, 99) < 5) now_acc = now_acc + $urandom_range(0, 70000);
                else                           now_acc = now_acc + $urandom_range(0, 400);
                if ($urandom_range(0, 99) < 2) now_acc = $urandom;   // jumps and wrap
                if ($urandom_range(0, 99) < 3) yaw_acc = 16'($urandom);
                else                           yaw_acc = yaw_acc + 16'($urandom_range(0, 4000));
                t.now = now_acc;
                t.yaw = yaw_acc;
                if (uturn_on) begin
                    t.wall = 2'($urandom);
                end else if (lost_run > 0) begin
                    t.wall = WALL_NONE;
                    lost_run--;
                end else if ($urandom_range(0, 99) < 8) begin
                    lost_run = $urandom_range(11, 13);
                    t.wall   = WALL_NONE;
                end else begin
                    t.wall = $urandom_range(0, 99) < 5 ? WALL_NONE : 2'($urandom_range(1, 3));
                end
                t.rho0 = $urandom_range(0, 99) < 80 ? 15'($urandom_range(0, 2700) - 200)
                                                    : 15'($urandom);
                t.rho1 = $urandom_range(0, 99) < 80 ? 15'($urandom_range(0, 2700) - 200)
                                                    : 15'($urandom);
                t.ang0 = $urandom_range(0, 99) < 60 ? 12'($urandom_range(0, 600) - 300)
                                                    : 12'($urandom);
                t.ang1 = $urandom_range(0, 99) < 60 ? 12'($urandom_range(0, 600) - 300)
                                                    : 12'($urandom);
                send_tick(t, 1'b0, '0);
            end
        end

        tick_ch.valid <= 1'b0;
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
        while (cmd_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: wall_follow_steering_with_uturn.f
sv/wfsu_pkg.sv
sv/wfsu_in_if.sv
sv/wfsu_out_if.sv
sv/wfsu_dpath.sv
sv/wfsu_ctrl.sv
sv/wall_follow_steering_with_uturn.sv
tb/wall_follow_steering_with_uturn_tb.sv
